### sv/rms_pkg.sv
package rms_pkg;

    localparam int SAMPLE_W = 32;
    localparam int TIME_W   = 63;
    localparam int CFG_W    = 7;
    localparam logic [CFG_W-1:0] WLEN_RESET = 7'd20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_SUM,
        S_MDIV,
        S_DEV,
        S_VDIV,
        S_SQRT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

### sv/rms_div.sv
module rms_div
    import rms_pkg::*;
#(
    parameter int DW = 70,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_ctl      i_ctl,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output t_div_ctl      o_ctl,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic          r_done;
    logic [VW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {r_rem, r_q[DW-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_ctl.start && r_busy && (r_cnt == CW'(DW - 1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DW-2:0], fits};
            if (fits) begin
                r_rem <= VW'(rem_sh - {1'b0, r_div});
            end else begin
                r_rem <= VW'(rem_sh);
            end
        end
    end

    assign o_ctl.start = r_busy;
    assign o_ctl.done  = r_done;
    assign o_quot      = r_q;
    assign o_rem       = r_rem;

endmodule

### sv/rolling_mean_and_std.sv
// Sliding-window mean and sample standard deviation of signed Q16.16 samples.
// Input channel: i_valid / o_stall with i_sample_time and i_sample_value. A
// transfer stores the sample in a ring of the last WINDOW_MAX samples.
// Output channel: o_valid / i_stall with window time, mean, std and std_valid.
// Once at least window_length samples are stored, each input gives one result;
// before that an input gives none and the block returns to idle from its
// check state. A result is worked out in order: one pass over the ring for the
// sum, a bit-serial divide for the mean, a second pass for squared deviations,
// a second bit-serial divide for the variance and a 32-step square root. A
// saturated std skips the root; len 1 skips the variance divide and the root.
// Both divides share one divider and both passes use the single ring read port.
// The next input is taken only once the last result is in the output register.
// o_stall stays high while an item is in work. A finished result sits in the
// output register; while the receiver stalls, the block still takes the next
// input and works it up to its result, then holds o_stall high until the
// register frees.
// Configuration: i_cfg_we writes i_cfg_data into window_length (reset 20);
// 0 acts as 1 and values above WINDOW_MAX act as WINDOW_MAX.
// Reset (i_rst_n low, synchronous) empties the ring and drops any result.
module rolling_mean_and_std
    import rms_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [TIME_W-1:0]          i_sample_time,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [TIME_W-1:0]          o_window_time,
    output logic signed [SAMPLE_W-1:0] o_window_mean,
    output logic [SAMPLE_W-1:0]        o_window_std,
    output logic                       o_std_valid
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int SW = 33 + AW;
    localparam int VW = 64 + AW;

    t_state r_state, n_state;

    logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
    logic [CFG_W-1:0]    r_wlen;
    logic [AW-1:0]       r_wp;
    logic [LW-1:0]       r_fill;
    logic [AW-1:0]       r_rd_ptr;
    logic [LW-1:0]       r_cnt;
    logic                r_rd_vld;
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [TIME_W-1:0]   r_time;
    logic signed [SW-1:0] r_sum;
    logic [SAMPLE_W-1:0] r_mean;
    logic                r_v2, r_v3;
    logic [31:0]         r_ad;
    logic [63:0]         r_prod;
    logic [VW-1:0]       r_acc;
    logic [63:0]         r_sx;
    logic [34:0]         r_srem;
    logic [31:0]         r_sres;
    logic [4:0]          r_scnt;
    logic [31:0]         r_std;
    logic                r_sv;

    logic [LW-1:0] len;
    logic [31:0]   len_i;
    logic          accept;
    logic          rd_en;
    logic          pass_done;
    t_div_ctl      div_in, div_out;
    logic [VW-1:0] div_dividend;
    logic [LW-1:0] div_divisor;
    logic [VW-1:0] div_quot;
    logic [LW-1:0] div_rem;
    logic [SW-1:0] sum_abs;
    logic signed [32:0] dev;
    logic [32:0]   dev_abs;
    logic [34:0]   srem_sh;
    logic [34:0]   strial;
    logic          out_free;

    always_comb begin
        len_i = 32'(r_wlen);
        if (len_i == 0) begin
            len_i = 32'd1;
        end else if (len_i > 32'(WINDOW_MAX)) begin
            len_i = 32'(WINDOW_MAX);
        end
        len = LW'(len_i);
    end

    assign accept    = i_valid && (r_state == S_IDLE);
    assign o_stall   = r_state != S_IDLE;
    assign rd_en     = (r_state == S_SUM || r_state == S_DEV) && (r_cnt != len);
    assign pass_done = (r_cnt == len) && !r_rd_vld && !r_v2 && !r_v3;
    assign out_free  = !o_valid || !i_stall;

    assign sum_abs = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign dev     = 33'(signed'(r_rd_data)) - 33'(signed'(r_mean));
    assign dev_abs = dev[32] ? 33'(-dev) : 33'(dev);
    assign srem_sh = {r_srem[32:0], r_sx[63:62]};
    assign strial  = {1'b0, r_sres, 2'b01};

    always_comb begin
        n_state      = r_state;
        div_in.start = 1'b0;
        div_in.done  = 1'b0;
        div_dividend = VW'(sum_abs);
        div_divisor  = len;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = (r_fill < len) ? S_IDLE : S_SUM;
            end
            S_SUM: begin
                if (pass_done) begin
                    div_in.start = 1'b1;
                    n_state      = S_MDIV;
                end
            end
            S_MDIV: begin
                if (div_out.done) begin
                    n_state = S_DEV;
                end
            end
            S_DEV: begin
                if (pass_done) begin
                    if (len == LW'(1)) begin
                        n_state = S_OUT;
                    end else begin
                        div_in.start = 1'b1;
                        div_dividend = r_acc;
                        div_divisor  = len - 1'b1;
                        n_state      = S_VDIV;
                    end
                end
            end
            S_VDIV: begin
                if (div_out.done) begin
                    n_state = (div_quot[VW-1:64] != '0) ? S_OUT : S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_scnt == 5'd31) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    rms_div #(
        .DW(VW),
        .VW(LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_in),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_ctl      (div_out),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_wp] <= i_sample_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen   <= WLEN_RESET;
            r_wp     <= '0;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_cnt    <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wlen <= i_cfg_data;
            end
            if (accept) begin
                r_wp <= (r_wp == AW'(WINDOW_MAX - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != LW'(WINDOW_MAX)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            r_rd_vld <= rd_en;
            r_v2     <= (r_state == S_DEV) && r_rd_vld;
            r_v3     <= r_v2;
            if (r_state == S_CHK || r_state == S_MDIV) begin
                r_cnt <= '0;
            end else if (rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time <= i_sample_time;
        end
        if (r_state == S_CHK || r_state == S_MDIV) begin
            r_rd_ptr <= (r_wp == '0) ? AW'(WINDOW_MAX - 1) : r_wp - 1'b1;
        end else if (rd_en) begin
            r_rd_ptr <= (r_rd_ptr == '0) ? AW'(WINDOW_MAX - 1) : r_rd_ptr - 1'b1;
        end
        if (r_state == S_CHK) begin
            r_sum <= '0;
        end else if (r_state == S_SUM && r_rd_vld) begin
            r_sum <= r_sum + SW'(signed'(r_rd_data));
        end
        if (r_state == S_MDIV && div_out.done) begin
            if (!r_sum[SW-1]) begin
                r_mean <= div_quot[SAMPLE_W-1:0];
            end else if (div_rem != '0) begin
                r_mean <= ~div_quot[SAMPLE_W-1:0];
            end else begin
                r_mean <= -div_quot[SAMPLE_W-1:0];
            end
        end
        r_ad   <= dev_abs[31:0];
        r_prod <= r_ad * r_ad;
        if (r_state == S_MDIV) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + VW'(r_prod);
        end
        if (r_state == S_DEV && pass_done && len == LW'(1)) begin
            r_std <= '0;
            r_sv  <= 1'b0;
        end
        if (r_state == S_VDIV && div_out.done) begin
            r_sv   <= 1'b1;
            r_std  <= '1;
            r_sx   <= div_quot[63:0];
            r_srem <= '0;
            r_sres <= '0;
            r_scnt <= '0;
        end
        if (r_state == S_SQRT) begin
            r_sx   <= {r_sx[61:0], 2'b00};
            r_scnt <= r_scnt + 1'b1;
            if (srem_sh >= strial) begin
                r_srem <= srem_sh - strial;
                r_sres <= {r_sres[30:0], 1'b1};
            end else begin
                r_srem <= srem_sh;
                r_sres <= {r_sres[30:0], 1'b0};
            end
            if (r_scnt == 5'd31) begin
                r_std <= {r_sres[30:0], srem_sh >= strial};
            end
        end
        if (r_state == S_OUT && out_free) begin
            o_window_time <= r_time;
            o_window_mean <= r_mean;
            o_window_std  <= r_std;
            o_std_valid   <= r_sv;
        end
    end

endmodule
